### src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int CAP_W         = 16;
    localparam int CHARS_W       = 16;
    localparam int GROUP_W       = 24;
    localparam int CMD_DEPTH     = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [CAP_W-1:0]   CAP_RESET     = 16'hFFFF;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [7:0]         PAD_CHAR      = 8'h3D;   // '='
    localparam logic [7:0]         OVF_CHAR      = 8'h00;
    localparam logic [5:0]         SEXTET_MASK   = 6'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       overflow;
    } out_item_t;

    // One encode command: a finished group, or an overflow marker.
    typedef struct packed {
        logic [GROUP_W-1:0] group_bits;   // left aligned, first byte high
        logic [1:0]         byte_count;   // 1..3
        logic               eom;
        logic               ovf;
    } cmd_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] s;
        s = {2'b00, sextet & SEXTET_MASK};
        if (s < 8'd26) begin
            return 8'h41 + s;
        end
        else if (s < 8'd52) begin
            return 8'h61 + (s - 8'd26);
        end
        else if (s < 8'd62) begin
            return 8'h30 + (s - 8'd52);
        end
        else if (s == 8'd62) begin
            return 8'h2B;
        end
        else begin
            return 8'h2F;
        end
    endfunction

endpackage

### src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Collects bytes into groups, checks capacity, issues encode commands.
// ----------------------------------------------------------------------------
module b64e_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,        // byte accepted this cycle
    input  b64e_pkg::in_item_t          item,
    input  logic [b64e_pkg::CAP_W-1:0]  capacity,
    output logic                        cmd_push,
    output b64e_pkg::cmd_t              cmd
);

    logic [15:0]                      held_bytes_reg, held_bytes_next;
    logic [1:0]                       held_count_reg, held_count_next;
    logic [b64e_pkg::CHARS_W-1:0]     chars_reg, chars_next;
    logic                             aborted_reg, aborted_next;

    logic [1:0]                       n;
    logic                             group_done;
    logic                             fits;
    logic [b64e_pkg::CHARS_W:0]       chars_plus4;

    assign n           = held_count_reg + 2'd1;
    assign group_done  = (n == 2'd3) || item.end_of_message;
    assign chars_plus4 = {1'b0, chars_reg} + (b64e_pkg::CHARS_W+1)'(4);
    assign fits        = chars_plus4 <= {1'b0, capacity};

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        chars_next      = chars_reg;
        aborted_next    = aborted_reg;
        cmd_push        = 1'b0;
        cmd.byte_count  = n;
        cmd.eom         = item.end_of_message;
        cmd.ovf         = !fits;
        unique case (held_count_reg)
            2'd0:    cmd.group_bits = {item.data_byte, 16'h0000};
            2'd1:    cmd.group_bits = {held_bytes_reg[7:0], item.data_byte, 8'h00};
            default: cmd.group_bits = {held_bytes_reg, item.data_byte};
        endcase

        if (take) begin
            if (aborted_reg) begin
                if (item.end_of_message) begin
                    aborted_next    = 1'b0;
                    held_bytes_next = '0;
                    held_count_next = '0;
                    chars_next      = '0;
                end
            end
            else if (!group_done) begin
                held_bytes_next = {held_bytes_reg[7:0], item.data_byte};
                held_count_next = n;
            end
            else begin
                cmd_push        = 1'b1;
                held_bytes_next = '0;
                held_count_next = '0;
                if (item.end_of_message) begin
                    chars_next = '0;
                end
                else if (fits) begin
                    chars_next = chars_plus4[b64e_pkg::CHARS_W-1:0];
                end
                else begin
                    aborted_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= '0;
            held_count_reg <= '0;
            chars_reg      <= '0;
            aborted_reg    <= 1'b0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
            chars_reg      <= chars_next;
            aborted_reg    <= aborted_next;
        end
    end

endmodule

### src/b64e_cmd_fifo.sv
// ----------------------------------------------------------------------------
// b64e_cmd_fifo
// Short register queue of encode commands between front and back.
// ----------------------------------------------------------------------------
module b64e_cmd_fifo
#(
    parameter int DEPTH = b64e_pkg::CMD_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  b64e_pkg::cmd_t  wr_cmd,
    output logic            full,
    input  logic            rd_en,
    output b64e_pkg::cmd_t  rd_cmd,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::cmd_t     slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slots[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Commands become characters in an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64e_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  b64e_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output b64e_pkg::out_item_t result,
    output logic                empty,
    input  logic                pop
);

    logic [1:0]             idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    b64e_pkg::out_item_t    out_reg, out_next;
    logic                   slot_free;
    logic                   emit;
    logic [5:0]             sextet;
    b64e_pkg::out_item_t    ch;

    assign slot_free = !out_valid_reg || pop;
    assign emit      = slot_free && !cmd_empty;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = cmd.group_bits[23:18];
            2'd1:    sextet = cmd.group_bits[17:12];
            2'd2:    sextet = cmd.group_bits[11:6];
            default: sextet = cmd.group_bits[5:0];
        endcase

        ch.out_char = b64e_pkg::b64_char(sextet);
        ch.out_last = 1'b0;
        ch.overflow = 1'b0;
        if (cmd.ovf) begin
            ch.out_char = b64e_pkg::OVF_CHAR;
            ch.out_last = 1'b1;
            ch.overflow = 1'b1;
        end
        else begin
            if ((idx_reg == 2'd2) && (cmd.byte_count < 2'd2)) begin
                ch.out_char = b64e_pkg::PAD_CHAR;
            end
            if (idx_reg == 2'd3) begin
                ch.out_last = cmd.eom;
                if (cmd.byte_count < 2'd3) begin
                    ch.out_char = b64e_pkg::PAD_CHAR;
                end
            end
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        cmd_pop        = 1'b0;
        if (emit) begin
            out_next       = ch;
            out_valid_next = 1'b1;
            if (cmd.ovf || (idx_reg == 2'd3)) begin
                cmd_pop  = 1'b1;
                idx_next = '0;
            end
            else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream to Base64 characters (standard alphabet, '=' padding).
// ----------------------------------------------------------------------------
// Bytes enter through a queue-style port (push/full) and characters leave
// through another (empty/pop). Every third byte of a message, or its final
// byte, closes a group that becomes four characters; short final groups are
// padded with '=' and the fourth character of the final group carries
// out_last. If a group would take the per-message character count past
// output_capacity, a single item with overflow=1, out_last=1 and out_char=0
// is produced instead and the rest of the message is dropped. A byte is
// accepted whenever the command queue (CMD_DEPTH entries) has room; the
// back end puts out one character per cycle while the character side keeps
// popping, so that a full group leaves as four characters in turn. A byte
// that closes a group is written into the command queue, and its first
// character then passes through the output register before it shows.
// output_capacity sits at byte address 0 of the APB port (reset 65535);
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module base64_stream_encoder
#(
    parameter int CMD_DEPTH = b64e_pkg::CMD_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // byte side
    input  logic                             push,
    output logic                             full,
    input  b64e_pkg::in_item_t               item,
    // character side
    output logic                             empty,
    input  logic                             pop,
    output b64e_pkg::out_item_t              result,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [b64e_pkg::PADDR_W-1:0]     paddr,
    input  logic [b64e_pkg::PDATA_W-1:0]     pwdata,
    output logic [b64e_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    logic [b64e_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic                       cap_hit;
    logic                       take;
    logic                       cmd_push;
    b64e_pkg::cmd_t             cmd_in;
    b64e_pkg::cmd_t             cmd_out;
    logic                       cmd_empty;
    logic                       cmd_pop;

    // ---- configuration register ----
    // Only paddr[2] selects a register; the byte offset bits are ignored.
    assign pready  = 1'b1;
    assign cap_hit = (paddr[b64e_pkg::PADDR_W-1] == b64e_pkg::ADDR_CAPACITY[b64e_pkg::PADDR_W-1]);
    assign prdata  = cap_hit ? {{(b64e_pkg::PDATA_W-b64e_pkg::CAP_W){1'b0}}, cap_reg} : '0;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && cap_hit) begin
            cap_next = pwdata[b64e_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= b64e_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // ---- front: grouping and capacity check ----
    // A byte is taken only while the queue has room, so a group that
    // closes on it always finds a slot.
    assign take = push && !full;

    b64e_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .capacity (cap_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // ---- decoupling queue ----
    b64e_cmd_fifo
    #(
        .DEPTH (CMD_DEPTH)
    )
    u_cmd_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_out),
        .empty  (cmd_empty)
    );

    // ---- back: character sequencer and output register ----
    b64e_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### tb/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Watches the byte, character and register ports of the Base64 encoder,
// predicts every character item and compares it with what the block returns.
// ----------------------------------------------------------------------------
module b64e_checker
    import b64e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  in_item_t           item,
    input  logic               empty,
    input  logic               pop,
    input  out_item_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending,
    output int                 chars_checked,
    output int                 overflows_checked
);

    string b64_symbols =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // shadow of the encoder state
    logic [CAP_W-1:0]   capacity;
    logic [15:0]        group_bytes;
    logic [1:0]         group_fill;
    logic [CHARS_W-1:0] msg_chars;
    logic               msg_dropped;

    out_item_t expected_chars[$];
    int        mismatches;

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] sextet);
        return b64_symbols[sextet];
    endfunction

    function automatic out_item_t char_item(input logic [7:0] ch, input logic last);
        out_item_t it;
        it.out_char = ch;
        it.out_last = last;
        it.overflow = 1'b0;
        return it;
    endfunction

    task automatic clear_message();
        group_bytes = '0;
        group_fill  = '0;
        msg_chars   = '0;
        msg_dropped = 1'b0;
    endtask

    // Advance the shadow state by one byte and queue the characters it yields.
    task automatic encode_byte(input in_item_t it);
        logic [GROUP_W-1:0] grp;
        int                 fill;
        out_item_t          ovf_item;
        if (msg_dropped)
        begin
            if (it.end_of_message)
            begin
                clear_message();
            end
            return;
        end
        fill = group_fill + 1;
        if (fill < 3 && !it.end_of_message)
        begin
            group_bytes = {group_bytes[7:0], it.data_byte};
            group_fill  = fill[1:0];
            return;
        end
        case (fill)
            1:       grp = {it.data_byte, 16'h0000};
            2:       grp = {group_bytes[7:0], it.data_byte, 8'h00};
            default: grp = {group_bytes, it.data_byte};
        endcase
        if (int'(msg_chars) + 4 > int'(capacity))
        begin
            ovf_item.out_char = OVF_CHAR;
            ovf_item.out_last = 1'b1;
            ovf_item.overflow = 1'b1;
            expected_chars.push_back(ovf_item);
            group_bytes = '0;
            group_fill  = '0;
            if (it.end_of_message)
            begin
                clear_message();
            end
            else
            begin
                msg_dropped = 1'b1;
            end
            return;
        end
        expected_chars.push_back(char_item(sextet_to_ascii(grp[23:18]), 1'b0));
        expected_chars.push_back(char_item(sextet_to_ascii(grp[17:12]), 1'b0));
        expected_chars.push_back(char_item(fill >= 2 ? sextet_to_ascii(grp[11:6])
                                                      : PAD_CHAR, 1'b0));
        expected_chars.push_back(char_item(fill >= 3 ? sextet_to_ascii(grp[5:0])
                                                      : PAD_CHAR,
                                           it.end_of_message));
        if (it.end_of_message)
        begin
            clear_message();
        end
        else
        begin
            msg_chars   = msg_chars + 16'd4;
            group_bytes = '0;
            group_fill  = '0;
        end
    endtask

    task automatic check_char(input out_item_t got);
        out_item_t want;
        if (expected_chars.size() == 0)
        begin
            $error("unexpected output item: char %h last %b overflow %b",
                   got.out_char, got.out_last, got.overflow);
            mismatches++;
            return;
        end
        want = expected_chars.pop_front();
        chars_checked <= chars_checked + 1;
        if (got.overflow)
        begin
            overflows_checked <= overflows_checked + 1;
        end
        if (got.out_char !== want.out_char)
        begin
            $error("out_char: expected %h, got %h", want.out_char, got.out_char);
            mismatches++;
        end
        if (got.out_last !== want.out_last)
        begin
            $error("out_last: expected %b, got %b", want.out_last, got.out_last);
            mismatches++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            clear_message();
            expected_chars.delete();
            mismatches = 0;
            fail_count        <= 0;
            pending           <= 0;
            chars_checked     <= 0;
            overflows_checked <= 0;
        end
        else
        begin
            // a popped character always belongs to an earlier byte
            if (pop && !empty)
            begin
                check_char(result);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY)
            begin
                capacity = pwdata[CAP_W-1:0];
            end
            if (push && !full)
            begin
                encode_byte(item);
            end
            fail_count <= mismatches;
            pending    <= expected_chars.size();
        end
    end

endmodule

### tb/tb_base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Stimulus and verdict for the Base64 stream encoder.
// ----------------------------------------------------------------------------
// Feeds whole messages of bytes into the encoder, first a handful of hand
// picked ones (padding, full groups, both non-letter symbols, overflow at the
// end of a message and in its middle, a zero capacity, an ignored register
// address), then random messages under several capacity settings. The
// sender runs in bursts with random gaps and the character side stalls on
// its own pattern. b64e_checker predicts and compares every character item;
// this module only drives the ports and reports the result.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;

    import b64e_pkg::*;

    // address with no register behind it; writes there must be ignored
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_LIMIT    = 2000;  // cycles with no transfer on any port

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    in_item_t           item    = '0;
    logic               empty;
    logic               pop     = 1'b0;
    out_item_t          result;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int chars_checked;
    int overflows_checked;

    // sender bookkeeping
    int burst_left   = 0;
    int bytes_sent   = 0;
    int msgs_sent    = 0;
    int reg_writes   = 0;

    // receiver pattern
    int rx_cycle = 0;
    int rx_mode  = 0;

    int idle_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    base64_stream_encoder DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    b64e_checker u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .item              (item),
        .empty             (empty),
        .pop               (pop),
        .result            (result),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .fail_count        (fail_count),
        .pending           (pending),
        .chars_checked     (chars_checked),
        .overflows_checked (overflows_checked)
    );

    // Character side: runs one of four stall patterns, redrawn at random. Mode 0 never
    // stalls, 1 is coin flips, 2 takes one item at evenly spaced points, 3 sits
    // through long stretches before draining a few.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 50 == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= (rx_cycle % 5 == 0);
            default: pop <= (rx_cycle % 16 >= 10);
        endcase
    end

    // Watchdog: ends the run if no port moves anything for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One byte into the encoder. push stays high across a burst; between
    // bursts it drops for a random gap, sometimes none at all.
    task automatic send_byte(input logic [7:0] data, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        item <= '{data_byte: data, end_of_message: eom};
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (eom)
        begin
            msgs_sent++;
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Register write, only once the encoder has drained everything owed.
    // Held bytes produce nothing, so wait a few extra cycles past the last
    // character before touching the register.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    // Random messages until about target bytes went in; lengths mostly
    // short, now and then long enough to run past a small capacity.
    task automatic random_phase(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_message($urandom_range(11, 20));
            end
            else
            begin
                send_message($urandom_range(1, 10));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, capacity at its reset value ---
        send_byte(8'h00, 1'b1);                 // one byte: two pads
        send_byte(8'hFF, 1'b0);                 // two bytes: one pad
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);                 // full group, no pad
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        send_byte(8'hFB, 1'b0);                 // '+' and '/', then short tail
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b1);

        // one group fits, the second overflows mid-message; rest dropped
        write_reg(ADDR_CAPACITY, 32'd4);
        for (int i = 1; i <= 7; i++)
        begin
            send_byte(8'(i), i == 7);
        end
        send_byte(8'h7E, 1'b1);                 // next message starts clean

        // nothing fits at all
        write_reg(ADDR_CAPACITY, 32'd0);
        send_byte(8'h10, 1'b1);

        // upper data bits are not part of the register
        write_reg(ADDR_CAPACITY, 32'hFFFF_0007);
        write_reg(ADDR_UNUSED, 32'd0);          // must leave capacity at 7
        for (int i = 0; i < 5; i++)
        begin
            send_byte(8'h31 + 8'(i), i == 4);   // overflow lands on the last byte
        end

        // --- random messages over several capacities ---
        write_reg(ADDR_CAPACITY, 32'd65535);
        random_phase(35);
        write_reg(ADDR_CAPACITY, 32'($urandom_range(0, 24)));
        random_phase(30);
        write_reg(ADDR_CAPACITY, 32'($urandom_range(0, 65535)));
        random_phase(30);

        // drain, then allow for anything the encoder might still send
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages with %0d register writes.",
                 bytes_sent, msgs_sent, reg_writes);
        $display("Checked %0d output items, %0d of them overflow markers.",
                 chars_checked, overflows_checked);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_cmd_fifo.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
tb/b64e_checker.sv
tb/tb_base64_stream_encoder.sv
